[hw/rtl/arge_pkg.sv]
// Shared types and constants for the audio region gain/fade editor.
// Holds the beat payload structs, the configuration struct, and the op codes.
// Used by every module in hw/rtl; depends on nothing else.
package arge_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAME_BITS  = 24;
    localparam int GAIN_BITS   = 24;
    localparam int GAIN_FRAC   = 16;
    localparam int MODE_BITS   = 3;
    localparam int CFG_BITS    = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int QDEPTH      = 2;

    localparam int OPND_BITS = (FRAME_BITS > GAIN_BITS) ? FRAME_BITS : GAIN_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + OPND_BITS;
    localparam int DIV_STEPS = SAMPLE_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_BITS-1:0] REG_EDIT_MODE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REGION_START = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REGION_END   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COUNT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_FACTOR  = 3'd4;

    localparam logic [MODE_BITS-1:0] MODE_PASS     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_GAIN     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SILENCE  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_FADE_IN  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FADE_OUT = 3'd4;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_GAIN,
        OP_ZERO,
        OP_SCALE
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_POST,
        BS_DIV,
        BS_FIN,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [FRAME_BITS-1:0]         frame_index;
        logic                          restart_peak;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          in_region;
        logic [SAMPLE_BITS-1:0]        peak_level;
    } t_out;

    typedef struct packed {
        logic [MODE_BITS-1:0]  edit_mode;
        logic [FRAME_BITS-1:0] region_start;
        logic [FRAME_BITS-1:0] region_end;
        logic [FRAME_BITS-1:0] frame_count;
        logic [GAIN_BITS-1:0]  gain_factor;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0]        mag;
        logic                          neg;
        logic                          in_rgn;
        logic                          restart;
        t_op                           op;
        logic [FRAME_BITS-1:0]         num;
        logic [FRAME_BITS-1:0]         len;
    } t_cmd;

endpackage

[hw/rtl/arge_front.sv]
// Front end: accepts input beats, clamps the region and classifies each sample.
// Emits one command per sample toward the queue.
// Depends on arge_pkg.
module arge_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  arge_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  arge_pkg::t_in  i_data,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output arge_pkg::t_cmd o_cmd
);
    import arge_pkg::*;

    logic                  r_valid;
    t_in                   r_item;
    logic [FRAME_BITS-1:0] r_st;
    logic [FRAME_BITS-1:0] r_en;
    logic [FRAME_BITS-1:0] st_c;
    logic [FRAME_BITS-1:0] en_c;
    logic [FRAME_BITS-1:0] en_min;
    logic                  in_rgn;
    logic                  neg;

    always_comb begin
        st_c   = (i_cfg.region_start < i_cfg.frame_count) ? i_cfg.region_start
                                                          : i_cfg.frame_count;
        en_min = (i_cfg.region_end < i_cfg.frame_count) ? i_cfg.region_end
                                                        : i_cfg.frame_count;
        en_c   = (en_min < st_c) ? st_c : en_min;
    end

    always_ff @(posedge i_clk) begin
        r_st <= st_c;
        r_en <= en_c;
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_data;
        end
    end

    always_comb begin
        in_rgn = (r_item.frame_index >= r_st) && (r_item.frame_index < r_en);
        neg    = r_item.sample_in[SAMPLE_BITS-1];

        o_cmd.sample  = r_item.sample_in;
        o_cmd.neg     = neg;
        o_cmd.mag     = neg ? (~r_item.sample_in + SAMPLE_BITS'(1)) : r_item.sample_in;
        o_cmd.in_rgn  = in_rgn;
        o_cmd.restart = r_item.restart_peak;
        o_cmd.len     = r_en - r_st;
        o_cmd.num     = (i_cfg.edit_mode == MODE_FADE_IN) ? (r_item.frame_index - r_st)
                                                          : (r_en - r_item.frame_index);
        o_cmd.op      = OP_PASS;
        if (in_rgn) begin
            unique case (i_cfg.edit_mode) inside
                MODE_GAIN:                   o_cmd.op = OP_GAIN;
                MODE_SILENCE:                o_cmd.op = OP_ZERO;
                MODE_FADE_IN, MODE_FADE_OUT: o_cmd.op = OP_SCALE;
                default:                     o_cmd.op = OP_PASS;
            endcase
        end
    end

endmodule

[hw/rtl/arge_fifo.sv]
// Short command queue between the front end and the execution back end.
// Holds QDEPTH commands in registers and reads out the oldest.
// Depends on arge_pkg.
module arge_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  arge_pkg::t_cmd i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output arge_pkg::t_cmd o_data
);
    import arge_pkg::*;

    localparam int PTR_BITS = $clog2(QDEPTH);
    localparam int CNT_W    = $clog2(QDEPTH + 1);

    t_cmd                r_mem [QDEPTH];
    logic [PTR_BITS-1:0] r_wr;
    logic [PTR_BITS-1:0] r_rd;
    logic [CNT_W-1:0]    r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_ready = (r_cnt != CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_BITS'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/arge_back.sv]
// Back end: executes one command at a time and keeps the running peak.
// Gain uses one multiply and a saturating shift; fades use a multiply and a
// restoring divider that resolves one quotient bit per cycle. Depends on arge_pkg.
module arge_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  arge_pkg::t_cfg i_cfg,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  arge_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output arge_pkg::t_out o_data
);
    import arge_pkg::*;

    localparam int QW = PROD_BITS - GAIN_FRAC + 1;
    localparam logic [QW-1:0] QMAXNEG = QW'(1) << (SAMPLE_BITS - 1);
    localparam logic [PROD_BITS:0] ROUND = (PROD_BITS + 1)'((1 << GAIN_FRAC) - 1);

    t_bstate                       r_state;
    t_bstate                       n_state;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic                          r_neg;
    logic                          r_inside;
    t_op                           r_op;
    logic [FRAME_BITS-1:0]         r_num;
    logic [FRAME_BITS-1:0]         r_len;
    logic [PROD_BITS-1:0]          r_prod;
    logic [FRAME_BITS-1:0]         r_rem;
    logic [SAMPLE_BITS-1:0]        r_quo;
    logic [CNT_BITS-1:0]           r_cnt;
    logic [SAMPLE_BITS-1:0]        r_peak;
    logic signed [SAMPLE_BITS-1:0] r_res;

    logic [SAMPLE_BITS-1:0] peak_base;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [OPND_BITS-1:0]   mult;
    logic [PROD_BITS:0]     rnd_sum;
    logic [QW-1:0]          q_neg;
    logic [SAMPLE_BITS-1:0] q_neg_sat;
    logic [SAMPLE_BITS-1:0] gain_res;
    logic [FRAME_BITS:0]    trial;
    logic                   trial_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        o_valid   = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_GAIN || i_cmd.op == OP_SCALE) begin
                        n_state = BS_MUL;
                    end else begin
                        n_state = BS_DONE;
                    end
                end
            end
            BS_MUL: n_state = BS_POST;
            BS_POST: begin
                n_state = (r_op == OP_GAIN) ? BS_DONE : BS_DIV;
            end
            BS_DIV: begin
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = BS_FIN;
                end
            end
            BS_FIN: n_state = BS_DONE;
            BS_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        peak_base = i_cmd.restart ? '0 : r_peak;
        n_peak    = (i_cmd.in_rgn && (i_cmd.mag > peak_base)) ? i_cmd.mag : peak_base;

        mult = (r_op == OP_GAIN) ? OPND_BITS'(i_cfg.gain_factor) : OPND_BITS'(r_num);

        rnd_sum   = {1'b0, r_prod} + ROUND;
        q_neg     = rnd_sum[PROD_BITS:GAIN_FRAC];
        q_neg_sat = (q_neg > QMAXNEG) ? QMAXNEG[SAMPLE_BITS-1:0] : q_neg[SAMPLE_BITS-1:0];
        if (r_neg) begin
            gain_res = ~q_neg_sat + SAMPLE_BITS'(1);
        end else if (|r_prod[PROD_BITS-1:GAIN_FRAC+SAMPLE_BITS-1]) begin
            gain_res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            gain_res = {1'b0, r_prod[GAIN_FRAC+SAMPLE_BITS-2:GAIN_FRAC]};
        end

        trial    = {r_rem, r_quo[SAMPLE_BITS-1]};
        trial_ge = (trial >= {1'b0, r_len});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (o_cmd_pop) begin
            r_peak <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= '0;
        unique case (r_state)
            BS_IDLE: begin
                if (o_cmd_pop) begin
                    r_sample <= i_cmd.sample;
                    r_mag    <= i_cmd.mag;
                    r_neg    <= i_cmd.neg;
                    r_inside <= i_cmd.in_rgn;
                    r_op     <= i_cmd.op;
                    r_num    <= i_cmd.num;
                    r_len    <= i_cmd.len;
                    r_res    <= (i_cmd.op == OP_ZERO) ? '0 : i_cmd.sample;
                end
            end
            BS_MUL: begin
                r_prod <= PROD_BITS'(r_mag) * PROD_BITS'(mult);
            end
            BS_POST: begin
                r_res <= gain_res;
                r_rem <= r_prod[SAMPLE_BITS+FRAME_BITS-1:SAMPLE_BITS];
                r_quo <= r_prod[SAMPLE_BITS-1:0];
            end
            BS_DIV: begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                r_rem <= trial_ge ? FRAME_BITS'(trial - {1'b0, r_len}) : trial[FRAME_BITS-1:0];
                r_quo <= {r_quo[SAMPLE_BITS-2:0], trial_ge};
            end
            BS_FIN: begin
                r_res <= r_neg ? (~r_quo + SAMPLE_BITS'(1)) : r_quo;
            end
            BS_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_data.sample_out = r_res;
    assign o_data.in_region  = r_inside;
    assign o_data.peak_level = r_peak;

`ifndef SYNTHESIS
    a_rem_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV) |-> (r_rem < r_len))
        else $error("Divider remainder reached the divisor.");

    a_peak_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BS_IDLE) |=> $stable(r_peak))
        else $error("Peak changed while a command was in flight.");

    a_outside_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.in_region) |-> (o_data.sample_out == r_sample))
        else $error("Sample outside the region was altered.");
`endif

endmodule

[hw/rtl/audio_region_gain_fade_editor.sv]
// Top level of the audio region gain/fade editor with peak meter.
// Holds the configuration registers and joins arge_front, arge_fifo and arge_back.
// Depends on arge_pkg.
//
//   Channel   Direction  Handshake            Payload
//   input     in         i_valid / o_ready    i_data (t_in)
//   output    out        o_valid / i_ready    o_data (t_out)
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Pass, silence and out-of-region samples go through the front-end register, the
// queue and the back end's IDLE and DONE states; gain adds MUL and POST, and fades add
// MUL, POST, the 24-step serial divider and FIN. The back end takes no new command until its last result is taken.
// Reset is synchronous and active low: configuration returns to its reset
// values, the peak clears to zero and the queue empties.
// The front end and a two-entry queue keep taking beats while a result waits.
module audio_region_gain_fade_editor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [arge_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [arge_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  arge_pkg::t_in                         i_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output arge_pkg::t_out                        o_data
);
    import arge_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_valid;
    logic queue_ready;
    logic queue_valid;
    logic back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edit_mode    <= MODE_PASS;
            r_cfg.region_start <= '0;
            r_cfg.region_end   <= '0;
            r_cfg.frame_count  <= '0;
            r_cfg.gain_factor  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EDIT_MODE:    r_cfg.edit_mode    <= i_cfg_data[MODE_BITS-1:0];
                REG_REGION_START: r_cfg.region_start <= i_cfg_data[FRAME_BITS-1:0];
                REG_REGION_END:   r_cfg.region_end   <= i_cfg_data[FRAME_BITS-1:0];
                REG_FRAME_COUNT:  r_cfg.frame_count  <= i_cfg_data[FRAME_BITS-1:0];
                REG_GAIN_FACTOR:  r_cfg.gain_factor  <= i_cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    arge_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready),
        .o_cmd       (front_cmd)
    );

    arge_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_data  (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_data  (queue_cmd)
    );

    arge_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (queue_valid),
        .o_cmd_pop   (back_pop),
        .i_cmd       (queue_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

[sim/audio_region_gain_fade_editor_tb.sv]
// Self-checking testbench for audio_region_gain_fade_editor: directed corner beats,
// then random region, mode and gain settings with random stalls on both channels.
// Depends on arge_pkg and the editor RTL; results are checked by an in-bench predictor.
`timescale 1ns / 100ps

module audio_region_gain_fade_editor_tb;
    import arge_pkg::*;

    localparam logic [63:0] POS_LIMIT = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic [63:0] NEG_LIMIT = 64'd1 << (SAMPLE_BITS - 1);
    localparam logic [63:0] FLOOR_BIAS = (64'd1 << GAIN_FRAC) - 64'd1;
    localparam int REG_NUM = 5;
    localparam int MODE_TOP = (1 << MODE_BITS) - 1;
    localparam int SETTLE_CYCLES = 40;

    class region_edit_scoreboard;
        logic [MODE_BITS-1:0]   mode;
        logic [FRAME_BITS-1:0]  req_start;
        logic [FRAME_BITS-1:0]  req_end;
        logic [FRAME_BITS-1:0]  frame_total;
        logic [GAIN_BITS-1:0]   gain;
        logic [SAMPLE_BITS-1:0] peak;
        t_out                   pending_beats[$];
        int                     errors;

        function new();
            mode        = MODE_PASS;
            req_start   = '0;
            req_end     = '0;
            frame_total = '0;
            gain        = GAIN_RESET;
            peak        = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_EDIT_MODE: begin
                    mode = data[MODE_BITS-1:0];
                end
                REG_REGION_START: begin
                    req_start = data[FRAME_BITS-1:0];
                end
                REG_REGION_END: begin
                    req_end = data[FRAME_BITS-1:0];
                end
                REG_FRAME_COUNT: begin
                    frame_total = data[FRAME_BITS-1:0];
                end
                REG_GAIN_FACTOR: begin
                    gain = data[GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void clamp_region(output logic [FRAME_BITS-1:0] first,
                                   output logic [FRAME_BITS-1:0] limit);
            first = (req_start < frame_total) ? req_start : frame_total;
            limit = (req_end < frame_total) ? req_end : frame_total;
            if (limit < first) limit = first;
        endfunction

        function void note_sample(t_in beat);
            logic [FRAME_BITS-1:0]  first;
            logic [FRAME_BITS-1:0]  limit;
            logic                   neg;
            logic                   in_rgn;
            logic [SAMPLE_BITS-1:0] mag;
            logic [63:0]            prod;
            logic [63:0]            quot;
            t_out                   res;
            clamp_region(first, limit);
            neg = beat.sample_in[SAMPLE_BITS-1];
            mag = neg ? (~beat.sample_in + SAMPLE_BITS'(1)) : beat.sample_in;
            in_rgn = (beat.frame_index >= first) && (beat.frame_index < limit);
            if (beat.restart_peak) peak = '0;
            res.sample_out = beat.sample_in;
            res.in_region = in_rgn;
            if (in_rgn) begin
                if (mag > peak) peak = mag;
                case (mode)
                    MODE_GAIN: begin
                        prod = 64'(mag) * 64'(gain);
                        if (!neg) begin
                            quot = prod >> GAIN_FRAC;
                            if (quot > POS_LIMIT) quot = POS_LIMIT;
                            res.sample_out = quot[SAMPLE_BITS-1:0];
                        end else begin
                            quot = (prod + FLOOR_BIAS) >> GAIN_FRAC;
                            if (quot > NEG_LIMIT) quot = NEG_LIMIT;
                            res.sample_out = SAMPLE_BITS'(64'd0 - quot);
                        end
                    end
                    MODE_SILENCE: begin
                        res.sample_out = '0;
                    end
                    MODE_FADE_IN, MODE_FADE_OUT: begin
                        if (mode == MODE_FADE_IN)
                            prod = 64'(mag) * 64'(beat.frame_index - first);
                        else
                            prod = 64'(mag) * 64'(limit - beat.frame_index);
                        quot = prod / 64'(limit - first);
                        res.sample_out = neg ? SAMPLE_BITS'(64'd0 - quot)
                                             : quot[SAMPLE_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            res.peak_level = peak;
            pending_beats = {pending_beats, res};
        endfunction

        function void report(string what, logic [SAMPLE_BITS-1:0] want,
                             logic [SAMPLE_BITS-1:0] got);
            $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.sample_out !== want.sample_out)
                report("sample_out", want.sample_out, got.sample_out);
            if (got.in_region !== want.in_region)
                report("in_region", SAMPLE_BITS'(want.in_region), SAMPLE_BITS'(got.in_region));
            if (got.peak_level !== want.peak_level)
                report("peak_level", want.peak_level, got.peak_level);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    t_in                     i_data;
    logic                    o_valid;
    logic                    i_ready;
    t_out                    o_data;

    region_edit_scoreboard sb;
    int send_idle_pct = 38;
    int recv_idle_pct = 58;

    audio_region_gain_fade_editor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample,
                               input logic [FRAME_BITS-1:0] frame, input logic restart);
        t_in beat;
        beat.sample_in    = sample;
        beat.frame_index  = frame;
        beat.restart_peak = restart;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(beat);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_BITS-1:0] mode_word,
                              input logic [FRAME_BITS-1:0] first,
                              input logic [FRAME_BITS-1:0] stop,
                              input logic [FRAME_BITS-1:0] count,
                              input logic [GAIN_BITS-1:0] gain);
        wait_idle();
        write_reg(REG_EDIT_MODE, mode_word);
        write_reg(REG_REGION_START, first);
        write_reg(REG_REGION_END, stop);
        write_reg(REG_FRAME_COUNT, count);
        write_reg(REG_GAIN_FACTOR, gain);
        write_reg(CFG_IDX_BITS'($urandom_range(REG_NUM, (1 << CFG_IDX_BITS) - 1)),
                  CFG_BITS'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("audio_region_gain_fade_editor verification failed");
        $finish;
    end

    initial begin
        logic [FRAME_BITS-1:0]  count;
        logic [FRAME_BITS-1:0]  first;
        logic [FRAME_BITS-1:0]  stop;
        logic [FRAME_BITS-1:0]  lo;
        logic [FRAME_BITS-1:0]  hi;
        logic [FRAME_BITS-1:0]  frame;
        logic [GAIN_BITS-1:0]   gain;
        logic [CFG_BITS-1:0]    word;
        logic [SAMPLE_BITS-1:0] samp;
        int                     seg;
        int                     n;

        sb = new();
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        i_ready    <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset frame count of zero leaves the region empty.
        send_sample(24'h7FFFFF, 24'h000000, 1'b0);
        send_sample(24'h800000, 24'hFFFFFF, 1'b1);

        set_config(CFG_BITS'(MODE_PASS), 24'd2, 24'd10, 24'd8, GAIN_RESET);
        send_sample(24'h800000, 24'd2, 1'b0);
        send_sample(24'h000064, 24'd7, 1'b0);
        send_sample(24'h000005, 24'd8, 1'b0);
        send_sample(24'h000003, 24'd1, 1'b1);

        set_config(CFG_BITS'(MODE_GAIN), 24'd0, 24'd16, 24'd16, '1);
        send_sample(24'h7FFFFF, 24'd0, 1'b0);
        send_sample(24'h800000, 24'd5, 1'b1);
        send_sample(24'hFFFFFF, 24'd9, 1'b0);
        send_sample(24'h000001, 24'd15, 1'b0);

        set_config(CFG_BITS'(MODE_GAIN), 24'd0, 24'd16, 24'd16, '0);
        send_sample(24'hFFFFFB, 24'd3, 1'b1);

        set_config(24'hFFFFF8 | CFG_BITS'(MODE_SILENCE), 24'd3, 24'd6, 24'd100, GAIN_RESET);
        send_sample(24'h123456, 24'd3, 1'b0);
        send_sample(24'h800000, 24'd5, 1'b0);
        send_sample(24'h7FFFFF, 24'd6, 1'b0);

        set_config(CFG_BITS'(MODE_FADE_IN), 24'd0, 24'd4, 24'd4, GAIN_RESET);
        send_sample(24'h800000, 24'd0, 1'b1);
        send_sample(24'h7FFFFF, 24'd1, 1'b0);
        send_sample(24'h800000, 24'd3, 1'b0);

        set_config(CFG_BITS'(MODE_FADE_OUT), 24'd0, 24'd4, 24'd4, GAIN_RESET);
        send_sample(24'h800000, 24'd0, 1'b1);
        send_sample(24'h7FFFFF, 24'd3, 1'b0);

        set_config(CFG_BITS'(MODE_TOP), 24'd0, 24'd2, '1, GAIN_RESET);
        send_sample(24'hFFFFB3, 24'd0, 1'b0);
        send_sample(24'h7FFFFF, 24'hFFFFFF, 1'b1);

        set_config(CFG_BITS'(MODE_GAIN), 24'd10, 24'd5, 24'd20, '1);
        send_sample(24'h400000, 24'd10, 1'b0);

        set_config(CFG_BITS'(MODE_SILENCE), '1, '1, '1, GAIN_RESET);
        send_sample(24'h7FFFFF, 24'hFFFFFF, 1'b0);

        for (seg = 0; seg < 15; seg++) begin
            if (seg == 5) begin
                send_idle_pct = 58;
                recv_idle_pct = 38;
            end else if (seg == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            word = CFG_BITS'(($urandom_range(99) < 85) ? $urandom_range(MODE_FADE_OUT)
                                                       : $urandom_range(MODE_FADE_OUT + 1, MODE_TOP));
            if ($urandom_range(3) == 0)
                word[CFG_BITS-1:MODE_BITS] = (CFG_BITS - MODE_BITS)'($urandom);
            case ($urandom_range(9))
                0: count = '0;
                1: count = '1;
                2: count = FRAME_BITS'($urandom);
                default: count = FRAME_BITS'($urandom_range(1, 256));
            endcase
            case ($urandom_range(5))
                0: first = '0;
                1: first = FRAME_BITS'($urandom);
                2: first = count + FRAME_BITS'($urandom_range(1, 8));
                default: first = FRAME_BITS'($urandom_range(0, count));
            endcase
            case ($urandom_range(6))
                0: stop = '1;
                1: stop = FRAME_BITS'($urandom);
                2: stop = first - FRAME_BITS'($urandom_range(1, 8));
                3: stop = first + FRAME_BITS'($urandom_range(0, 64));
                default: stop = FRAME_BITS'($urandom_range(first, count));
            endcase
            case ($urandom_range(5))
                0: gain = '0;
                1: gain = '1;
                2: gain = GAIN_RESET;
                3: gain = GAIN_BITS'($urandom);
                default: gain = GAIN_BITS'($urandom_range(0, 1 << 18));
            endcase
            set_config(word, first, stop, count, gain);
            sb.clamp_region(lo, hi);

            for (n = 0; n < 130; n++) begin
                case ($urandom_range(9))
                    0: frame = FRAME_BITS'($urandom);
                    1: frame = '0;
                    2: frame = '1;
                    3: frame = hi;
                    4: frame = lo - FRAME_BITS'(1);
                    default: frame = FRAME_BITS'($urandom_range(lo, hi));
                endcase
                case ($urandom_range(7))
                    0: samp = 24'h800000;
                    1: samp = 24'h7FFFFF;
                    2: samp = SAMPLE_BITS'($urandom_range(15)) - 24'd8;
                    default: samp = SAMPLE_BITS'($urandom);
                endcase
                send_sample(samp, frame, $urandom_range(15) == 0);
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("audio_region_gain_fade_editor verification clean");
        else
            $display("audio_region_gain_fade_editor verification failed");
        $finish;
    end
endmodule
